/* hdl/cobs_frame_encoder_assert.svh */
// Assertion macros used by the encoder's checker
`ifndef COBS_FRAME_ENCODER_ASSERT_SVH
`define COBS_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication, masked during reset
`define CFE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, masked during reset
`define CFE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, live through reset
`define CFE_ASSERT_NXT_NR(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* hdl/cfe_pkg.sv */
// Constants and types shared by the COBS encoder modules
`default_nettype none

package cfe_pkg;

  localparam int MAX_RUN    = 254;
  localparam int WORD_BYTES = 8;

  localparam int DATA_W = 8;
  localparam int WORD_W = 64;
  localparam int CNT_W  = 4;
  localparam int CFG_W  = 16;

  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int ADDR_W = $clog2(MAX_RUN);
  localparam int LEN_W  = $clog2(MAX_RUN + 3);
  localparam int POS_W  = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

  localparam logic [CFG_W-1:0]  MAX_LEN_RESET = '1;
  localparam logic [DATA_W-1:0] EMPTY_CODE    = 8'h01;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } cfe_state_t;

  typedef struct packed {
    logic in_ready;
    logic start;
    logic abort;
    logic step;
    logic push;
  } cfe_cmd_t;

  typedef struct packed {
    logic flush;
    logic ovf;
    logic stream_end;
    logic word_done;
    logic out_busy;
  } cfe_status_t;

endpackage

`default_nettype wire

/* hdl/cfe_ifs.sv */
// Request channel interfaces: raw byte input and encoded word output
`default_nettype none

interface cfe_byte_if;
  import cfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              byte_present;
  logic              frame_last;

  modport source (output valid, data_byte, byte_present, frame_last, input ready);
  modport sink   (input valid, data_byte, byte_present, frame_last, output ready);
endinterface

interface cfe_word_if;
  import cfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic [CNT_W-1:0]  byte_count;
  logic              frame_end;
  logic              overflow;
  logic              batch_last;

  modport source (output valid, out_word, byte_count, frame_end, overflow, batch_last,
                  input ready);
  modport sink   (input valid, out_word, byte_count, frame_end, overflow, batch_last,
                  output ready);
endinterface

`default_nettype wire

/* hdl/cobs_frame_encoder.sv */
// Streaming COBS frame encoder, top level
//
//   channel  | dir | handshake     | carries
//   raw      | in  | valid/ready   | data_byte, byte_present, frame_last
//   coded    | out | valid/ready   | out_word, byte_count, frame_end, overflow, batch_last
//   cfg      | in  | cfg_we        | max_output_len (cfg_wdata)
//
// A request that only buffers a byte, is dropped or overflows is done once accepted.
// A request that flushes is accepted, then emits its encoded bytes one at a time
// (run length + 1, or + 2 with a closing 0x01) through the run store's single
// read port, a finished word waiting while the output register is still held.
// A new request is taken once the last word is gone or leaving that cycle.
// rst is synchronous; the run store is not cleared and needs no clearing pass.
`default_nettype none

module cobs_frame_encoder (
  input  logic                      clk,
  input  logic                      rst,
  cfe_byte_if.sink                  raw,
  cfe_word_if.source                coded,
  input  logic                      cfg_we,
  input  logic [cfe_pkg::CFG_W-1:0] cfg_wdata
);
  import cfe_pkg::*;

  cfe_cmd_t    cmd;
  cfe_status_t status;

  cfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (raw.valid),
    .status   (status),
    .cmd      (cmd)
  );

  cfe_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_valid     (raw.valid),
    .data_byte    (raw.data_byte),
    .byte_present (raw.byte_present),
    .frame_last   (raw.frame_last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .coded        (coded)
  );

  assign raw.ready = cmd.in_ready;

endmodule

`default_nettype wire

/* hdl/cfe_ctrl.sv */
// Controller: accepts requests and sequences the byte-by-byte flush
`default_nettype none

module cfe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  cfe_pkg::cfe_status_t status,
  output cfe_pkg::cfe_cmd_t    cmd
);
  import cfe_pkg::*;

  cfe_state_t state;
  cfe_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.step && status.stream_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = !status.out_busy;
        cmd.start    = in_valid && cmd.in_ready && status.flush && !status.ovf;
        cmd.abort    = in_valid && cmd.in_ready && status.flush && status.ovf;
      end
      ST_EMIT: begin
        // a finished word waits while the output register is still held
        cmd.step = !(status.word_done && status.out_busy);
        cmd.push = cmd.step && status.word_done;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/cfe_datapath.sv */
// Datapath: run store, frame counters, limit check, word packing, output register
`default_nettype none

module cfe_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  cfe_pkg::cfe_cmd_t            cmd,
  output cfe_pkg::cfe_status_t         status,
  input  logic                         in_valid,
  input  logic [cfe_pkg::DATA_W-1:0]   data_byte,
  input  logic                         byte_present,
  input  logic                         frame_last,
  input  logic                         cfg_we,
  input  logic [cfe_pkg::CFG_W-1:0]    cfg_wdata,
  cfe_word_if.source                   coded
);
  import cfe_pkg::*;

  logic [DATA_W-1:0] run_store [0:MAX_RUN-1];

  logic [RUN_W-1:0]  run_length;
  logic [CFG_W-1:0]  emitted_count;
  logic              dropping;
  logic [CFG_W-1:0]  max_len;

  logic              accept;
  logic              nonzero;
  logic              run_full;
  logic              extra;
  logic [RUN_W-1:0]  item_run;
  logic [LEN_W-1:0]  item_n_m1;
  logic [CFG_W:0]    total;

  logic [RUN_W-1:0]  code_len;
  logic [LEN_W-1:0]  n_m1;
  logic              last_q;
  logic [LEN_W-1:0]  j;
  logic [LEN_W-1:0]  j_next;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] cur_byte;

  logic [WORD_W-1:0] word_acc;
  logic [WORD_W-1:0] word_new;
  logic [POS_W-1:0]  pos;

  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic [CNT_W-1:0]  out_count;
  logic              out_end;
  logic              out_ovf;
  logic              out_blast;

  assign accept = in_valid && cmd.in_ready;

  // item decode: run after this byte, and the stream length it flushes
  always_comb begin
    nonzero  = byte_present && (data_byte != '0);
    item_run = nonzero ? run_length + RUN_W'(1) : run_length;
    run_full = nonzero && (item_run == RUN_W'(MAX_RUN));
    extra    = frame_last && byte_present && (!nonzero || run_full);
    item_n_m1 = LEN_W'(item_run) + LEN_W'(extra);
    total    = {1'b0, emitted_count} + (CFG_W+1)'(item_n_m1) + (CFG_W+1)'(1);
  end

  always_comb begin
    status.flush      = !dropping && ((byte_present && !nonzero) || run_full || frame_last);
    status.ovf        = total > {1'b0, max_len};
    status.stream_end = (j == n_m1);
    status.word_done  = status.stream_end || (pos == POS_W'(WORD_BYTES - 1));
    status.out_busy   = out_valid && !coded.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length    <= '0;
      emitted_count <= '0;
      dropping      <= 1'b0;
    end else if (accept) begin
      if (dropping) begin
        if (frame_last) begin
          dropping <= 1'b0;
        end
      end else if (cmd.abort) begin
        run_length    <= '0;
        emitted_count <= '0;
        dropping      <= !frame_last;
      end else if (cmd.start) begin
        run_length    <= '0;
        emitted_count <= frame_last ? '0 : CFG_W'(total);
      end else begin
        run_length <= item_run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      code_len <= item_run;
      n_m1     <= item_n_m1;
      last_q   <= frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !dropping && nonzero) begin
      run_store[run_length[ADDR_W-1:0]] <= data_byte;
    end
  end

  // read one ahead so that byte j sees run_store[j-1]; stalls hold the address
  always_comb begin
    if (cmd.start) begin
      j_next = '0;
    end else if (cmd.step) begin
      j_next = j + LEN_W'(1);
    end else begin
      j_next = j;
    end
    rd_addr = ADDR_W'(j_next - LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    j <= j_next;
    if ({1'b0, rd_addr} < (ADDR_W+1)'(MAX_RUN)) begin
      rd_data <= run_store[rd_addr];
    end
  end

  always_comb begin
    priority if (j == '0) begin
      cur_byte = DATA_W'(code_len + RUN_W'(1));
    end else if (j <= LEN_W'(code_len)) begin
      cur_byte = rd_data;
    end else begin
      cur_byte = EMPTY_CODE;
    end
  end

  always_comb begin
    word_new = word_acc;
    for (int b = 0; b < WORD_BYTES; b++) begin
      if (pos == POS_W'(b)) begin
        word_new[DATA_W*b +: DATA_W] = cur_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.push) begin
      word_acc <= '0;
      pos      <= '0;
    end else if (cmd.step) begin
      word_acc <= word_new;
      pos      <= pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push || cmd.abort) begin
      out_valid <= 1'b1;
    end else if (coded.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_word  <= word_new;
      out_count <= CNT_W'(pos) + CNT_W'(1);
      out_end   <= status.stream_end && last_q;
      out_ovf   <= 1'b0;
      out_blast <= status.stream_end;
    end else if (cmd.abort) begin
      out_word  <= '0;
      out_count <= '0;
      out_end   <= 1'b1;
      out_ovf   <= 1'b1;
      out_blast <= 1'b1;
    end
  end

  assign coded.valid      = out_valid;
  assign coded.out_word   = out_word;
  assign coded.byte_count = out_count;
  assign coded.frame_end  = out_end;
  assign coded.overflow   = out_ovf;
  assign coded.batch_last = out_blast;

endmodule

`default_nettype wire

/* hdl/cfe_checker.sv */
// Port-level checker for the COBS encoder, bound to the top level
`default_nettype none

`include "cobs_frame_encoder_assert.svh"

module cfe_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic [cfe_pkg::CNT_W-1:0] byte_count,
  input logic                      frame_end,
  input logic                      overflow,
  input logic                      batch_last
);
  import cfe_pkg::*;

  `CFE_ASSERT_IMP(a_ovf_shape, clk, rst, out_valid && overflow, byte_count == '0 && frame_end && batch_last)
  `CFE_ASSERT_IMP(a_count_range, clk, rst, out_valid && !overflow, byte_count != '0 && byte_count <= CNT_W'(WORD_BYTES))
  `CFE_ASSERT_IMP(a_end_closes_batch, clk, rst, out_valid && frame_end, batch_last)
  `CFE_ASSERT_IMP(a_no_take_mid_batch, clk, rst, out_valid && !batch_last, !in_ready)
  `CFE_ASSERT_NXT_NR(a_reset_empties_out, clk, rst, !out_valid)

endmodule

bind cobs_frame_encoder cfe_checker u_cfe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (raw.ready),
  .out_valid  (coded.valid),
  .byte_count (coded.byte_count),
  .frame_end  (coded.frame_end),
  .overflow   (coded.overflow),
  .batch_last (coded.batch_last)
);

`default_nettype wire

/* bench/tb.sv */
// Testbench for the streaming COBS frame encoder: directed and random frames, checked word by word
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfe_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_STALL  = 600;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              byte_present;
    logic              frame_last;
  } byte_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic [CNT_W-1:0]  byte_count;
    logic              frame_end;
    logic              overflow;
    logic              batch_last;
  } coded_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  cfe_byte_if raw_ch ();
  cfe_word_if coded_ch ();

  cobs_frame_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .raw       (raw_ch),
    .coded     (coded_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // encoder state as predicted
  logic [DATA_W-1:0] run_buf [0:MAX_RUN-1];
  int                run_len;
  int                frame_emitted;
  bit                dropping;
  int                max_len;
  logic [DATA_W-1:0] item_bytes [$];

  byte_req_t   pending_reqs [$];
  coded_word_t expected_words [$];
  byte_req_t   cur_req;

  int queued_reqs;
  int fail_count;
  int cycle_count;
  int send_gap;
  int recv_stall;
  bit idle_en;
  logic long_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // code byte then the run's bytes onto this request's output stream
  function automatic void close_run();
    if (item_bytes.size() + run_len + 1 > MAX_RUN + 2) return;
    item_bytes.push_back(8'(run_len + 1));
    for (int i = 0; i < run_len; i++) item_bytes.push_back(run_buf[i]);
    run_len = 0;
  endfunction

  function automatic void encode_request(input byte_req_t r);
    coded_word_t w;
    int n;
    if (dropping) begin
      if (r.frame_last) dropping = 1'b0;
      return;
    end
    item_bytes.delete();
    if (r.byte_present) begin
      if (r.data_byte == 8'h00) begin
        close_run();
      end else begin
        if (run_len < MAX_RUN) begin
          run_buf[run_len] = r.data_byte;
          run_len++;
        end
        if (run_len >= MAX_RUN) close_run();
      end
    end
    if (r.frame_last) close_run();
    if (item_bytes.size() == 0) return;

    if (frame_emitted + item_bytes.size() > max_len) begin
      w = '0;
      w.overflow   = 1'b1;
      w.frame_end  = 1'b1;
      w.batch_last = 1'b1;
      expected_words.push_back(w);
      run_len       = 0;
      frame_emitted = 0;
      dropping      = !r.frame_last;
      return;
    end

    frame_emitted = r.frame_last ? 0 : (frame_emitted + item_bytes.size()) & 16'hFFFF;
    for (int pos = 0; pos < item_bytes.size(); pos += WORD_BYTES) begin
      n = item_bytes.size() - pos;
      if (n > WORD_BYTES) n = WORD_BYTES;
      w = '0;
      for (int b = 0; b < n; b++) w.out_word[8*b +: 8] = item_bytes[pos + b];
      w.byte_count = CNT_W'(n);
      w.batch_last = (pos + n >= item_bytes.size());
      w.frame_end  = w.batch_last && r.frame_last;
      expected_words.push_back(w);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [WORD_W-1:0] exp_v,
                                        input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      raw_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!raw_ch.valid || raw_ch.ready) begin
      if (raw_ch.valid) encode_request(cur_req);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        raw_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        raw_ch.data_byte    <= cur_req.data_byte;
        raw_ch.byte_present <= cur_req.byte_present;
        raw_ch.frame_last   <= cur_req.frame_last;
        raw_ch.valid        <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 18);
      end else begin
        raw_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      coded_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (coded_ch.valid && coded_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_word %0h byte_count %0d overflow %0b",
                 coded_ch.out_word, coded_ch.byte_count, coded_ch.overflow);
          fail_count++;
        end else begin
          coded_word_t e;
          e = expected_words.pop_front();
          compare_field("out_word", e.out_word, coded_ch.out_word);
          compare_field("byte_count", e.byte_count, coded_ch.byte_count);
          compare_field("frame_end", e.frame_end, coded_ch.frame_end);
          compare_field("overflow", e.overflow, coded_ch.overflow);
          compare_field("batch_last", e.batch_last, coded_ch.batch_last);
        end
      end
      if (long_stall) begin
        coded_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        coded_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        recv_stall <= $urandom_range(0, 17);
        coded_ch.ready <= 1'b0;
      end else begin
        coded_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void push_req(input logic [DATA_W-1:0] d, input logic present,
                                   input logic last);
    byte_req_t r;
    r.data_byte    = d;
    r.byte_present = present;
    r.frame_last   = last;
    pending_reqs.push_back(r);
    queued_reqs++;
  endfunction

  // n_bytes data bytes, zero_pct percent of them zero; ends on a bare marker or the last byte
  task automatic queue_frame(input int n_bytes, input int zero_pct, input bit end_marker);
    logic [DATA_W-1:0] d;
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 15) == 0) push_req(8'($urandom), 1'b0, 1'b0);
      d = ($urandom_range(1, 100) <= zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
      push_req(d, 1'b1, !end_marker && i == n_bytes - 1);
    end
    if (end_marker || n_bytes == 0) push_req(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic queue_random_frames(input int n_reqs);
    int target;
    int len;
    int zp;
    target = queued_reqs + n_reqs;
    while (queued_reqs < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      case ($urandom_range(0, 3))
        0: zp = 0;
        1: zp = 10;
        2: zp = 30;
        default: zp = 70;
      endcase
      queue_frame(len, zp, $urandom_range(0, 3) == 0);
    end
  endtask

  // wait until every request is taken, every word is out and idle counters have run down
  task automatic settle();
    while (pending_reqs.size() != 0 || raw_ch.valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    max_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    raw_ch.valid = 1'b0;
    raw_ch.data_byte = '0;
    raw_ch.byte_present = 1'b0;
    raw_ch.frame_last = 1'b0;
    coded_ch.ready = 1'b0;
    long_stall = 1'b0;
    idle_en = 1'b1;
    run_len = 0;
    frame_emitted = 0;
    dropping = 1'b0;
    max_len = MAX_LEN_RESET;
    queued_reqs = 0;
    fail_count = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_limit(16'hFFFF);
    push_req(8'hA5, 1'b0, 1'b1);   // empty frame
    push_req(8'h00, 1'b1, 1'b1);
    push_req(8'hFF, 1'b1, 1'b1);
    push_req(8'h01, 1'b1, 1'b0);
    push_req(8'h7E, 1'b0, 1'b0);   // bare marker mid-frame
    push_req(8'h00, 1'b1, 1'b0);
    push_req(8'h80, 1'b1, 1'b0);
    push_req(8'hFF, 1'b1, 1'b1);
    push_req(8'h00, 1'b1, 1'b0);
    push_req(8'h00, 1'b1, 1'b0);
    push_req(8'h3C, 1'b0, 1'b1);
    settle();

    // limit of one byte: overflow, drop to frame end, overflow on the last request
    write_limit(16'd1);
    push_req(8'h55, 1'b1, 1'b0);
    push_req(8'h00, 1'b1, 1'b0);
    push_req(8'h12, 1'b1, 1'b0);
    push_req(8'h00, 1'b1, 1'b1);
    push_req(8'hC3, 1'b0, 1'b1);
    push_req(8'h33, 1'b1, 1'b1);
    push_req(8'h44, 1'b1, 1'b0);
    push_req(8'h00, 1'b0, 1'b1);
    push_req(8'h00, 1'b1, 1'b1);
    settle();

    write_limit(16'($urandom_range(8, 40)));
    queue_random_frames(40);
    settle();

    // two short frames fill the output side, then a full run flushes and the frame goes on
    write_limit(16'hFFFF);
    push_req(8'h11, 1'b1, 1'b1);
    push_req(8'h22, 1'b1, 1'b1);
    queue_frame(MAX_RUN + 2, 0, 1'b1);
    @(posedge clk);
    long_stall <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    long_stall <= 1'b0;
    @(negedge clk);
    settle();

    write_limit(16'($urandom_range(2, 7)));
    queue_random_frames(10);
    settle();

    idle_en = 1'b0;
    write_limit(16'($urandom_range(100, 1000)));
    queue_random_frames(15);
    settle();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/cfe_pkg.sv
hdl/cfe_ifs.sv
hdl/cfe_ctrl.sv
hdl/cfe_datapath.sv
hdl/cobs_frame_encoder.sv
hdl/cfe_checker.sv
bench/tb.sv
